// ----- rtl/jdcd_pkg.sv -----
// ----------------------------------------------------------------------------
// jdcd_pkg
// Shared constants and types for the Julian day to calendar date converter.
// Reciprocals are rounded up so that floor(x * M >> K) equals floor(x / d)
// for every dividend that fits in the stated width.
// ----------------------------------------------------------------------------
package jdcd_pkg;

	localparam logic [38:0] HALF_DAY_SECS = 39'd43200;
	localparam logic [21:0] GREG_SWITCH   = 22'd2299161;

	// z = floor(x / 675), x below 2^32
	localparam int          DAY_K   = 42;
	localparam logic [32:0] M_DAY   = 33'(((64'd1 << DAY_K) / 64'd675) + 64'd1);
	localparam logic [31:0] DAY_DIV = 32'd675;

	// alpha = floor(n / 146097), n below 2^23
	localparam int          ALPHA_K = 41;
	localparam logic [23:0] M_ALPHA = 24'(((64'd1 << ALPHA_K) / 64'd146097) + 64'd1);

	// C = floor(n / 7305), n below 2^26
	localparam int          C_K = 39;
	localparam logic [26:0] M_C = 27'(((64'd1 << C_K) / 64'd7305) + 64'd1);

	// E = floor(n / 306001), n below 2^24
	localparam int          E_K = 43;
	localparam logic [24:0] M_E = 25'(((64'd1 << E_K) / 64'd306001) + 64'd1);

	// floor(n / 10000), n below 2^24
	localparam int          F_K = 38;
	localparam logic [24:0] M_F = 25'(((64'd1 << F_K) / 64'd10000) + 64'd1);

	localparam logic [21:0] B_OFFSET  = 22'd1524;
	localparam logic [25:0] C_OFFSET  = 26'd2442;
	localparam logic [24:0] D_MUL     = 25'd1461;
	localparam logic [23:0] E_MUL     = 24'd10000;
	localparam logic [23:0] F_MUL     = 24'd306001;
	localparam logic [23:0] ALPHA_OFS = 24'd7468865;
	localparam logic [15:0] YEAR_LATE = 16'd4716;
	localparam logic [15:0] YEAR_EARLY = 16'd4715;

	typedef struct packed {
		logic        nz;
		logic [21:0] z;
		logic [16:0] sec;
	} day_split_t;

endpackage

// ----- rtl/jdcd_day_split.sv -----
// ----------------------------------------------------------------------------
// jdcd_day_split
// Three pipeline stages that round the second count to a day number and
// split off the second of the day. Division by 86400 is a shift by 7 and a
// reciprocal multiply by 1/675 with an exact remainder.
// ----------------------------------------------------------------------------
module jdcd_day_split (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    in_vld,
	input  logic [37:0]             seconds,
	output logic                    out_vld,
	output jdcd_pkg::day_split_t    split
);

	logic [38:0] sum_c;
	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] x_s1, x_s2;
	logic [6:0]  lo_s1, lo_s2;
	logic        nz_s1, nz_s2;
	logic [64:0] prod_c, prod_s2;
	logic [21:0] z_c;
	logic [31:0] zmul_c, rem_c;
	jdcd_pkg::day_split_t split_s3;

	assign sum_c  = {1'b0, seconds} + jdcd_pkg::HALF_DAY_SECS;
	assign prod_c = 65'(x_s1) * 65'(jdcd_pkg::M_DAY);
	assign z_c    = prod_s2[jdcd_pkg::DAY_K +: 22];
	assign zmul_c = 32'(z_c) * jdcd_pkg::DAY_DIV;
	assign rem_c  = x_s2 - zmul_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1         <= sum_c[38:7];
			lo_s1        <= sum_c[6:0];
			nz_s1        <= (seconds != '0);
			prod_s2      <= prod_c;
			x_s2         <= x_s1;
			lo_s2        <= lo_s1;
			nz_s2        <= nz_s1;
			split_s3.nz  <= nz_s2;
			split_s3.z   <= z_c;
			split_s3.sec <= {rem_c[9:0], lo_s2};
		end
	end

	assign out_vld = vld_s3;
	assign split   = split_s3;

endmodule

// ----- rtl/julian_day_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// Meeus conversion of a Julian date in seconds to year, month, day and
// second of the day, in exact integer form.
// ----------------------------------------------------------------------------
// Input channel: seconds_valid / seconds_stall carry julian_seconds, the
// Julian date times 86400. An item is taken on a clock edge with valid high
// and stall low.
// Output channel: date_valid / date_stall carry valid_res, year, month,
// day_of_month and second_of_day. A zero input gives the null date: valid_res
// low and all other fields zero. Day numbers below 2299161 use the Julian
// calendar. The year wraps modulo 65536.
// One item enters per cycle while date_stall does not hold the pipeline; the
// fourteen stages each hold one divide-by-reciprocal multiply or a few narrow
// adds, and the whole pipeline moves as one.
// When the receiver stalls with a result waiting, every stage holds and
// seconds_stall goes high in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seconds_valid,
	output logic        seconds_stall,
	input  logic [37:0] julian_seconds,
	output logic        date_valid,
	input  logic        date_stall,
	output logic        valid_res,
	output logic [15:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [16:0] second_of_day
);

	logic advance;
	logic vld_s3;
	jdcd_pkg::day_split_t split_s3;

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;

	logic        greg_c;
	logic [22:0] anum_c;
	logic [21:0] z_s4, z_s5;
	logic        greg_s4, greg_s5;
	logic [22:0] anum_s4;
	logic [46:0] aprod_c, aprod_s5;
	logic [5:0]  alpha_c;
	logic [21:0] a_c, b_s6, b_s7, b_s8;
	logic [25:0] cnum_s7;
	logic [52:0] cprod_c, cprod_s8;
	logic [13:0] c_c, c_s9, c_s10, c_s11, c_s12, c_s13;
	logic [24:0] dprod_c;
	logic [22:0] bd_full_c;
	logic [9:0]  bd_s9, bd_s10, bd_s11, bd_s12, bd_s13;
	logic [23:0] enum_s10;
	logic [48:0] eprod_c, eprod_s11;
	logic [4:0]  e_c, e_s12, e_s13;
	logic [23:0] fnum_s12;
	logic [48:0] fprod_c, fprod_s13;
	logic [9:0]  f_c, day_c;
	logic [3:0]  month_c;
	logic [15:0] year_c;

	logic        nz_s4, nz_s5, nz_s6, nz_s7, nz_s8, nz_s9;
	logic        nz_s10, nz_s11, nz_s12, nz_s13;
	logic [16:0] sec_s4, sec_s5, sec_s6, sec_s7, sec_s8, sec_s9;
	logic [16:0] sec_s10, sec_s11, sec_s12, sec_s13;

	logic        valid_res_s14;
	logic [15:0] year_s14;
	logic [3:0]  month_s14;
	logic [4:0]  day_s14;
	logic [16:0] sec_s14;

	// hold every stage while a finished result waits
	assign advance       = !(vld_s14 && date_stall);
	assign seconds_stall = !advance;

	jdcd_day_split u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_vld  (seconds_valid),
		.seconds (julian_seconds),
		.out_vld (vld_s3),
		.split   (split_s3)
	);

	// Gregorian correction numerator
	assign greg_c  = (split_s3.z >= jdcd_pkg::GREG_SWITCH);
	assign anum_c  = greg_c ? 23'({split_s3.z, 2'b00} - jdcd_pkg::ALPHA_OFS) : '0;
	assign aprod_c = 47'(anum_s4) * 47'(jdcd_pkg::M_ALPHA);

	assign alpha_c = aprod_s5[jdcd_pkg::ALPHA_K +: 6];
	assign a_c     = greg_s5 ? z_s5 + 22'd1 + 22'(alpha_c) - 22'(alpha_c[5:2]) : z_s5;

	assign cprod_c   = 53'(cnum_s7) * 53'(jdcd_pkg::M_C);
	assign c_c       = cprod_s8[jdcd_pkg::C_K +: 14];
	assign dprod_c   = 25'(c_c) * jdcd_pkg::D_MUL;
	assign bd_full_c = 23'(b_s8) - dprod_c[24:2];

	assign eprod_c = 49'(enum_s10) * 49'(jdcd_pkg::M_E);
	assign e_c     = eprod_s11[jdcd_pkg::E_K +: 5];

	assign fprod_c = 49'(fnum_s12) * 49'(jdcd_pkg::M_F);
	assign f_c     = fprod_s13[jdcd_pkg::F_K +: 10];
	assign day_c   = bd_s13 - f_c;
	assign month_c = (e_s13 < 5'd14) ? 4'(e_s13 - 5'd1) : 4'(e_s13 - 5'd13);
	assign year_c  = (month_c > 4'd2) ? 16'(c_s13) - jdcd_pkg::YEAR_LATE
	                                  : 16'(c_s13) - jdcd_pkg::YEAR_EARLY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (advance) begin
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			z_s4     <= split_s3.z;
			greg_s4  <= greg_c;
			anum_s4  <= anum_c;
			nz_s4    <= split_s3.nz;
			sec_s4   <= split_s3.sec;

			aprod_s5 <= aprod_c;
			z_s5     <= z_s4;
			greg_s5  <= greg_s4;
			nz_s5    <= nz_s4;
			sec_s5   <= sec_s4;

			b_s6     <= a_c + jdcd_pkg::B_OFFSET;
			nz_s6    <= nz_s5;
			sec_s6   <= sec_s5;

			cnum_s7  <= 26'({b_s6, 4'b0000}) + 26'({b_s6, 2'b00}) - jdcd_pkg::C_OFFSET;
			b_s7     <= b_s6;
			nz_s7    <= nz_s6;
			sec_s7   <= sec_s6;

			cprod_s8 <= cprod_c;
			b_s8     <= b_s7;
			nz_s8    <= nz_s7;
			sec_s8   <= sec_s7;

			c_s9     <= c_c;
			bd_s9    <= bd_full_c[9:0];
			nz_s9    <= nz_s8;
			sec_s9   <= sec_s8;

			enum_s10 <= 24'(bd_s9) * jdcd_pkg::E_MUL;
			c_s10    <= c_s9;
			bd_s10   <= bd_s9;
			nz_s10   <= nz_s9;
			sec_s10  <= sec_s9;

			eprod_s11 <= eprod_c;
			c_s11     <= c_s10;
			bd_s11    <= bd_s10;
			nz_s11    <= nz_s10;
			sec_s11   <= sec_s10;

			e_s12    <= e_c;
			fnum_s12 <= 24'(e_c) * jdcd_pkg::F_MUL;
			c_s12    <= c_s11;
			bd_s12   <= bd_s11;
			nz_s12   <= nz_s11;
			sec_s12  <= sec_s11;

			fprod_s13 <= fprod_c;
			e_s13     <= e_s12;
			c_s13     <= c_s12;
			bd_s13    <= bd_s12;
			nz_s13    <= nz_s12;
			sec_s13   <= sec_s12;

			// null date: zero every field
			valid_res_s14 <= nz_s13;
			year_s14      <= nz_s13 ? year_c : '0;
			month_s14     <= nz_s13 ? month_c : '0;
			day_s14       <= nz_s13 ? day_c[4:0] : '0;
			sec_s14       <= nz_s13 ? sec_s13 : '0;
		end
	end

	assign date_valid    = vld_s14;
	assign valid_res     = valid_res_s14;
	assign year          = year_s14;
	assign month         = month_s14;
	assign day_of_month  = day_s14;
	assign second_of_day = sec_s14;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for julian_day_to_calendar_date. A date predictor converts every
// accepted Julian second count to year, month, day and second of the day.
// Each returned date is compared field by field with the oldest prediction.
// The stimulus has a directed set of edge values followed by random inputs,
// run under several idle and stall phases, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          LATENCY        = 14;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam int          HOLD_OFF_LEN   = 300;
	localparam int          RANDOM_PER_PHASE = 500;
	localparam logic [63:0] SECS_PER_DAY   = 64'd86400;
	localparam logic [63:0] HALF_DAY       = 64'd43200;
	localparam logic [63:0] GREGORIAN_DAY  = 64'd2299161;
	localparam logic [63:0] LAST_FULL_DAY  = 64'd3181456;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [16:0] second_of_day;
	} cal_date_t;

	// Meeus conversion in exact integer steps
	function automatic cal_date_t convert_seconds(input logic [37:0] secs);
		logic [63:0] s, z, sod, alpha, a, b, c, d, e, day, mon, yr;
		cal_date_t   r;
		r = '0;
		s = 64'(secs);
		if (s == 64'd0)
			return r;
		z = (s + HALF_DAY) / SECS_PER_DAY;
		sod = s + HALF_DAY - z * SECS_PER_DAY;
		if (z < GREGORIAN_DAY) begin
			a = z;
		end else begin
			alpha = (64'd4 * z - 64'd7468865) / 64'd146097;
			a = z + 64'd1 + alpha - alpha / 64'd4;
		end
		b = a + 64'd1524;
		c = (64'd20 * b - 64'd2442) / 64'd7305;
		d = (64'd1461 * c) / 64'd4;
		e = (64'd10000 * (b - d)) / 64'd306001;
		day = b - d - (64'd306001 * e) / 64'd10000;
		mon = (e < 64'd14) ? e - 64'd1 : e - 64'd13;
		// early years go negative and wrap
		yr = (mon > 64'd2) ? c - 64'd4716 : c - 64'd4715;
		r.valid_res = 1'b1;
		r.year = yr[15:0];
		r.month = mon[3:0];
		r.day_of_month = day[4:0];
		r.second_of_day = sod[16:0];
		return r;
	endfunction

	class date_scoreboard;
		cal_date_t pending[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function void note_seconds(input logic [37:0] secs);
			pending.push_back(convert_seconds(secs));
		endfunction

		function void report(input string field, input logic [63:0] want,
				input logic [63:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_date(input cal_date_t got);
			cal_date_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: date with no input pending, expected none, got %0d-%0d-%0d",
					$time, got.year, got.month, got.day_of_month);
				return;
			end
			want = pending.pop_front();
			if (got.valid_res !== want.valid_res)
				report("valid_res", 64'(want.valid_res), 64'(got.valid_res));
			if (got.year !== want.year)
				report("year", 64'(want.year), 64'(got.year));
			if (got.month !== want.month)
				report("month", 64'(want.month), 64'(got.month));
			if (got.day_of_month !== want.day_of_month)
				report("day_of_month", 64'(want.day_of_month), 64'(got.day_of_month));
			if (got.second_of_day !== want.second_of_day)
				report("second_of_day", 64'(want.second_of_day), 64'(got.second_of_day));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        seconds_valid;
	logic        seconds_stall;
	logic [37:0] julian_seconds;
	logic        date_valid;
	logic        date_stall;
	logic        valid_res;
	logic [15:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [16:0] second_of_day;

	date_scoreboard board;
	int send_idle_pct;
	int stall_pct;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int quiet_cycles;

	julian_day_to_calendar_date dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.seconds_valid (seconds_valid),
		.seconds_stall (seconds_stall),
		.julian_seconds(julian_seconds),
		.date_valid    (date_valid),
		.date_stall    (date_stall),
		.valid_res     (valid_res),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month),
		.second_of_day (second_of_day)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_OFF_LEN - 1;
			date_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			date_stall <= 1'b1;
		end else begin
			date_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// note accepted inputs and check accepted dates
	always @(posedge clk) begin
		if (arst_n) begin
			if (seconds_valid && !seconds_stall)
				board.note_seconds(julian_seconds);
			if (date_valid && !date_stall)
				board.check_date({valid_res, year, month, day_of_month, second_of_day});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (seconds_valid && !seconds_stall) || (date_valid && !date_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_seconds(input logic [37:0] secs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			seconds_valid <= 1'b0;
			@(posedge clk);
		end
		seconds_valid <= 1'b1;
		julian_seconds <= secs;
		do @(posedge clk); while (seconds_stall);
	endtask

	// stop offering and wait for every pending date
	task automatic drain_dates();
		seconds_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [37:0] seconds_at(input logic [63:0] z, input logic [63:0] sod);
		logic [63:0] s;
		s = z * SECS_PER_DAY - HALF_DAY + sod;
		return s[37:0];
	endfunction

	function automatic logic [37:0] random_seconds();
		logic [63:0] z;
		logic [63:0] sod;
		case ($urandom_range(0, 5))
			0, 1: return {6'($urandom_range(0, 63)), 32'($urandom)};
			2: begin
				// years 1900 to 2100
				z = 64'($urandom_range(2415021, 2488070));
				return seconds_at(z, 64'($urandom_range(0, 86399)));
			end
			3: begin
				// around the calendar switch
				z = 64'($urandom_range(2299161 - 800, 2299161 + 800));
				return seconds_at(z, 64'($urandom_range(0, 86399)));
			end
			4: begin
				// tiny inputs give negative years
				if ($urandom_range(0, 3) == 0)
					return 38'($urandom_range(0, 3));
				return 38'($urandom_range(0, 400000000));
			end
			default: begin
				z = 64'($urandom_range(1, 3181456));
				case ($urandom_range(0, 3))
					0: sod = 64'd0;
					1: sod = 64'd1;
					2: sod = 64'd86398;
					default: sod = 64'd86399;
				endcase
				return seconds_at(z, sod);
			end
		endcase
	endfunction

	logic [37:0] directed[$];

	initial begin
		board = new();
		arst_n = 1'b0;
		seconds_valid <= 1'b0;
		julian_seconds <= '0;
		date_stall <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{38'd0, 38'd1, 38'd43199, 38'd43200, 38'd86399, 38'd86400,
			38'h3F_FFFF_FFFF, 38'h2A_AAAA_AAAA, 38'h15_5555_5555,
			seconds_at(GREGORIAN_DAY - 64'd1, 64'd0),
			seconds_at(GREGORIAN_DAY - 64'd1, 64'd86399),
			seconds_at(GREGORIAN_DAY, 64'd0),
			seconds_at(GREGORIAN_DAY, 64'd86399),
			seconds_at(64'd2451545, 64'd43200),
			seconds_at(64'd2451544, 64'd86399),
			seconds_at(64'd2451604, 64'd0),
			seconds_at(64'd2415079, 64'd86399),
			seconds_at(64'd2415080, 64'd0),
			seconds_at(LAST_FULL_DAY, 64'd86399),
			seconds_at(64'd1, 64'd0)};

		// phase with no idling; the hold-off fills the pipeline
		hold_requests <= 1;
		foreach (directed[i])
			send_seconds(directed[i]);
		repeat (RANDOM_PER_PHASE)
			send_seconds(random_seconds());
		drain_dates();

		send_idle_pct = 67;
		stall_pct = 0;
		repeat (RANDOM_PER_PHASE)
			send_seconds(random_seconds());
		drain_dates();

		send_idle_pct = 0;
		stall_pct = 67;
		repeat (RANDOM_PER_PHASE)
			send_seconds(random_seconds());
		drain_dates();

		send_idle_pct = 31;
		stall_pct = 31;
		repeat (RANDOM_PER_PHASE)
			send_seconds(random_seconds());
		drain_dates();

		stall_pct = 0;
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
